/* rtl/core/rbst_pkg.sv */
// ----------------------------------------------------------------------------
// rbst_pkg
// shared types and constants for the ray / box slab test core
// ----------------------------------------------------------------------------
`default_nettype none

package rbst_pkg;

  localparam int COORD_W       = 32;
  localparam int LIM_W         = 31;
  localparam int NUM_LANES     = 4;
  localparam int FRAC_BITS_DEF = 16;

  // one divider lane per box edge
  localparam int LANE_MIN_X = 0;
  localparam int LANE_MAX_X = 1;
  localparam int LANE_MIN_Y = 2;
  localparam int LANE_MAX_Y = 3;

  typedef enum logic [1:0] {
    REG_BOX_MIN_X = 2'd0,
    REG_BOX_MIN_Y = 2'd1,
    REG_BOX_MAX_X = 2'd2,
    REG_BOX_MAX_Y = 2'd3
  } reg_index_t;

  // per-lane sign and zero-direction info riding along with the quotient
  typedef struct packed {
    logic neg;      // quotient is negative
    logic zdir;     // direction component is zero
    logic inf_pos;  // with zdir: crossing is +inf, else -inf
  } lane_flags_t;

endpackage

`default_nettype wire

/* rtl/core/ray_box_slab_test_core.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// 2d ray versus axis-aligned box, slab method, fixed point
// ----------------------------------------------------------------------------
// One ray per item is tested against the box held in four registers. The core
// takes a new item every cycle while in_stall is low; each item passes through
// one set-up stage, a row of FRAC_BITS + 33 division cells that each resolve
// one quotient bit for all four box edges at once, two compare stages and the
// output register. Throughput is one item per cycle as long as out_stall stays
// low. A skid register behind the output holds one extra result, so in_stall
// rises only once both are full. Box registers are written through cfg_we /
// cfg_index / cfg_data and should only change while no item is in flight.
`default_nettype none

module ray_box_slab_test_core #(
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [rbst_pkg::COORD_W-1:0]         cfg_data,
  // ray items in
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [rbst_pkg::COORD_W-1:0]  origin_x,
  input  wire logic signed [rbst_pkg::COORD_W-1:0]  origin_y,
  input  wire logic signed [rbst_pkg::COORD_W-1:0]  dir_x,
  input  wire logic signed [rbst_pkg::COORD_W-1:0]  dir_y,
  input  wire logic [rbst_pkg::LIM_W-1:0]           length_limit,
  // result items out
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      hit,
  output logic [rbst_pkg::LIM_W-1:0]                t_enter,
  output logic signed [rbst_pkg::COORD_W-1:0]       t_exit
);
  import rbst_pkg::*;

  // quotient width: 33-bit difference magnitude shifted by the fraction
  localparam int QW = COORD_W + 1 + FRAC_BITS;
  // crossing width: quotient, sign and room for the infinity marks
  localparam int CW = QW + 2;

  localparam logic signed [CW-1:0] EN_MAX = {{(CW-LIM_W){1'b0}}, {LIM_W{1'b1}}};
  localparam logic signed [CW-1:0] EX_MIN = {{(CW-LIM_W){1'b1}}, {LIM_W{1'b0}}};

  // box registers
  logic signed [COORD_W-1:0] box_min_x, box_min_y, box_max_x, box_max_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_BOX_MIN_X: box_min_x <= cfg_data;
        REG_BOX_MIN_Y: box_min_y <= cfg_data;
        REG_BOX_MAX_X: box_max_x <= cfg_data;
        REG_BOX_MAX_Y: box_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe moves unless the skid register is holding a result
  logic skid_full;
  logic pipe_en;

  assign pipe_en  = !skid_full;
  assign in_stall = skid_full;

  // chain taps: index 0 is the set-up stage, QW is the last cell
  logic                               c_valid [QW+1];
  logic [LIM_W-1:0]                   c_lim   [QW+1];
  lane_flags_t [NUM_LANES-1:0]        c_flags [QW+1];
  logic [NUM_LANES-1:0][31:0]         c_div   [QW+1];
  logic [NUM_LANES-1:0][31:0]         c_rem   [QW+1];
  logic [NUM_LANES-1:0][QW-1:0]       c_dvd   [QW+1];
  logic [NUM_LANES-1:0][QW-1:0]       c_quo   [QW+1];

  // set-up: per edge difference magnitude, divisor magnitude and flags
  logic signed [COORD_W-1:0]    lane_edge [NUM_LANES];
  logic signed [COORD_W-1:0]    lane_org  [NUM_LANES];
  logic signed [COORD_W-1:0]    lane_dir  [NUM_LANES];
  lane_flags_t [NUM_LANES-1:0]  prep_flags;
  logic [NUM_LANES-1:0][31:0]   prep_div;
  logic [NUM_LANES-1:0][QW-1:0] prep_dvd;

  always_comb begin
    lane_edge[LANE_MIN_X] = box_min_x;
    lane_edge[LANE_MAX_X] = box_max_x;
    lane_edge[LANE_MIN_Y] = box_min_y;
    lane_edge[LANE_MAX_Y] = box_max_y;
    lane_org[LANE_MIN_X]  = origin_x;
    lane_org[LANE_MAX_X]  = origin_x;
    lane_org[LANE_MIN_Y]  = origin_y;
    lane_org[LANE_MAX_Y]  = origin_y;
    lane_dir[LANE_MIN_X]  = dir_x;
    lane_dir[LANE_MAX_X]  = dir_x;
    lane_dir[LANE_MIN_Y]  = dir_y;
    lane_dir[LANE_MAX_Y]  = dir_y;
  end

  always_comb begin
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        dmag;
    logic                    is_max;
    for (int l = 0; l < NUM_LANES; l++) begin
      diff   = {lane_edge[l][COORD_W-1], lane_edge[l]} - {lane_org[l][COORD_W-1], lane_org[l]};
      dmag   = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
      is_max = (l == LANE_MAX_X) || (l == LANE_MAX_Y);
      prep_dvd[l]           = {dmag, {FRAC_BITS{1'b0}}};
      prep_div[l]           = lane_dir[l][COORD_W-1] ? 32'(-lane_dir[l]) : lane_dir[l];
      prep_flags[l].neg     = diff[COORD_W] ^ lane_dir[l][COORD_W-1];
      prep_flags[l].zdir    = (lane_dir[l] == '0);
      // on the boundary a min edge counts as -inf and a max edge as +inf
      prep_flags[l].inf_pos = (!diff[COORD_W] && (diff != '0)) || ((diff == '0) && is_max);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (pipe_en) begin
      c_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c_lim[0]   <= length_limit;
      c_flags[0] <= prep_flags;
      c_div[0]   <= prep_div;
      c_rem[0]   <= '0;
      c_dvd[0]   <= prep_dvd;
      c_quo[0]   <= '0;
    end
  end

  // division row: one quotient bit per cell
  for (genvar g = 0; g < QW; g++) begin : g_cell
    rbst_cell #(
      .QW (QW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (pipe_en),
      .up_valid (c_valid[g]),
      .up_lim   (c_lim[g]),
      .up_flags (c_flags[g]),
      .up_div   (c_div[g]),
      .up_rem   (c_rem[g]),
      .up_dvd   (c_dvd[g]),
      .up_quo   (c_quo[g]),
      .dn_valid (c_valid[g+1]),
      .dn_lim   (c_lim[g+1]),
      .dn_flags (c_flags[g+1]),
      .dn_div   (c_div[g+1]),
      .dn_rem   (c_rem[g+1]),
      .dn_dvd   (c_dvd[g+1]),
      .dn_quo   (c_quo[g+1])
    );
  end

  // entry / exit across both axes
  logic                 b_valid;
  logic [LIM_W-1:0]     b_lim;
  logic signed [CW-1:0] b_tmin, b_tmax;

  rbst_combine #(
    .QW (QW),
    .CW (CW)
  ) u_combine (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .up_valid (c_valid[QW]),
    .up_lim   (c_lim[QW]),
    .up_flags (c_flags[QW]),
    .up_quo   (c_quo[QW]),
    .dn_valid (b_valid),
    .dn_lim   (b_lim),
    .tmin     (b_tmin),
    .tmax     (b_tmax)
  );

  // hit test and clipping
  logic signed [CW-1:0]      lim_ext;
  logic signed [CW-1:0]      ex_pre;
  logic                      res_hit;
  logic [LIM_W-1:0]          res_enter;
  logic signed [COORD_W-1:0] res_exit;

  always_comb begin
    lim_ext = {{(CW-LIM_W){1'b0}}, b_lim};
    res_hit = !(b_tmax[CW-1] || (b_tmin > lim_ext) || (b_tmin > b_tmax));
    if (b_tmin[CW-1]) begin
      res_enter = '0;
    end else if (b_tmin > EN_MAX) begin
      res_enter = {LIM_W{1'b1}};
    end else begin
      res_enter = b_tmin[LIM_W-1:0];
    end
    ex_pre = (b_tmax < lim_ext) ? b_tmax : lim_ext;
    if (ex_pre < EX_MIN) begin
      res_exit = EX_MIN[COORD_W-1:0];
    end else begin
      res_exit = ex_pre[COORD_W-1:0];
    end
  end

  // output register with one-entry skid
  logic                      load_new;
  logic                      skid_hit;
  logic [LIM_W-1:0]          skid_enter;
  logic signed [COORD_W-1:0] skid_exit;

  assign load_new = b_valid && pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (load_new) begin
        skid_full <= 1'b1;
      end
    end else if (skid_full) begin
      out_valid <= 1'b1;
      skid_full <= 1'b0;
    end else begin
      out_valid <= load_new;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (load_new) begin
        skid_hit   <= res_hit;
        skid_enter <= res_enter;
        skid_exit  <= res_exit;
      end
    end else if (skid_full) begin
      hit     <= skid_hit;
      t_enter <= skid_enter;
      t_exit  <= skid_exit;
    end else if (load_new) begin
      hit     <= res_hit;
      t_enter <= res_enter;
      t_exit  <= res_exit;
    end
  end

  // skid only holds a result behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid full while output register empty");

  // skid fills only from a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(out_valid && out_stall))
    else $error("skid filled without output stall");

  // a taken output with a full skid drains the skid next
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && skid_full) |=> (out_valid && !skid_full))
    else $error("skid did not drain into output");

  // input is held off exactly while the skid is occupied
  a_stall_skid: assert property (@(posedge clk) disable iff (rst)
    in_stall == skid_full)
    else $error("input stall out of step with skid");

endmodule

`default_nettype wire

/* rtl/core/rbst_cell.sv */
// ----------------------------------------------------------------------------
// rbst_cell
// one restoring-division step for all four lanes, registered
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_cell #(
  parameter int QW = 49
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire logic                                            en,
  input  wire logic                                            up_valid,
  input  wire logic [rbst_pkg::LIM_W-1:0]                      up_lim,
  input  wire rbst_pkg::lane_flags_t [rbst_pkg::NUM_LANES-1:0] up_flags,
  input  wire logic [rbst_pkg::NUM_LANES-1:0][31:0]            up_div,
  input  wire logic [rbst_pkg::NUM_LANES-1:0][31:0]            up_rem,
  input  wire logic [rbst_pkg::NUM_LANES-1:0][QW-1:0]          up_dvd,
  input  wire logic [rbst_pkg::NUM_LANES-1:0][QW-1:0]          up_quo,
  output logic                                                 dn_valid,
  output logic [rbst_pkg::LIM_W-1:0]                           dn_lim,
  output rbst_pkg::lane_flags_t [rbst_pkg::NUM_LANES-1:0]      dn_flags,
  output logic [rbst_pkg::NUM_LANES-1:0][31:0]                 dn_div,
  output logic [rbst_pkg::NUM_LANES-1:0][31:0]                 dn_rem,
  output logic [rbst_pkg::NUM_LANES-1:0][QW-1:0]               dn_dvd,
  output logic [rbst_pkg::NUM_LANES-1:0][QW-1:0]               dn_quo
);
  import rbst_pkg::*;

  logic [NUM_LANES-1:0][31:0] rem_next;
  logic [NUM_LANES-1:0]       qbit;

  always_comb begin
    logic [32:0] trial;
    for (int l = 0; l < NUM_LANES; l++) begin
      trial = {up_rem[l], up_dvd[l][QW-1]};
      qbit[l] = (trial >= {1'b0, up_div[l]});
      if (qbit[l]) begin
        rem_next[l] = 32'(trial - {1'b0, up_div[l]});
      end else begin
        rem_next[l] = trial[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_lim   <= up_lim;
      dn_flags <= up_flags;
      dn_div   <= up_div;
      dn_rem   <= rem_next;
      for (int l = 0; l < NUM_LANES; l++) begin
        dn_dvd[l] <= {up_dvd[l][QW-2:0], 1'b0};
        dn_quo[l] <= {up_quo[l][QW-2:0], qbit[l]};
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rbst_combine.sv */
// ----------------------------------------------------------------------------
// rbst_combine
// signed crossings, per-axis ordering, then entry / exit across axes
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_combine #(
  parameter int QW = 49,
  parameter int CW = QW + 2
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire logic                                            en,
  input  wire logic                                            up_valid,
  input  wire logic [rbst_pkg::LIM_W-1:0]                      up_lim,
  input  wire rbst_pkg::lane_flags_t [rbst_pkg::NUM_LANES-1:0] up_flags,
  input  wire logic [rbst_pkg::NUM_LANES-1:0][QW-1:0]          up_quo,
  output logic                                                 dn_valid,
  output logic [rbst_pkg::LIM_W-1:0]                           dn_lim,
  output logic signed [CW-1:0]                                 tmin,
  output logic signed [CW-1:0]                                 tmax
);
  import rbst_pkg::*;

  localparam logic signed [CW-1:0] POS_INF = {2'b01, {QW{1'b0}}};
  localparam logic signed [CW-1:0] NEG_INF = {2'b11, {QW{1'b0}}};

  logic signed [CW-1:0] xing [NUM_LANES];
  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic                 a_valid;
  logic [LIM_W-1:0]     a_lim;

  always_comb begin
    logic signed [CW-1:0] mag;
    for (int l = 0; l < NUM_LANES; l++) begin
      mag = {2'b00, up_quo[l]};
      if (up_flags[l].zdir) begin
        xing[l] = up_flags[l].inf_pos ? POS_INF : NEG_INF;
      end else begin
        xing[l] = up_flags[l].neg ? -mag : mag;
      end
    end
  end

  // first stage: order each axis pair
  always_ff @(posedge clk) begin
    if (en) begin
      a_lim <= up_lim;
      if (xing[LANE_MIN_X] < xing[LANE_MAX_X]) begin
        lo_x <= xing[LANE_MIN_X];
        hi_x <= xing[LANE_MAX_X];
      end else begin
        lo_x <= xing[LANE_MAX_X];
        hi_x <= xing[LANE_MIN_X];
      end
      if (xing[LANE_MIN_Y] < xing[LANE_MAX_Y]) begin
        lo_y <= xing[LANE_MIN_Y];
        hi_y <= xing[LANE_MAX_Y];
      end else begin
        lo_y <= xing[LANE_MAX_Y];
        hi_y <= xing[LANE_MIN_Y];
      end
    end
  end

  // second stage: latest entry, earliest exit
  always_ff @(posedge clk) begin
    if (en) begin
      dn_lim <= a_lim;
      tmin   <= (lo_y > lo_x) ? lo_y : lo_x;
      tmax   <= (hi_y < hi_x) ? hi_y : hi_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      dn_valid <= 1'b0;
    end else if (en) begin
      a_valid  <= up_valid;
      dn_valid <= a_valid;
    end
  end

endmodule

`default_nettype wire
